// ===== rtl/cmps_pkg.sv =====
`default_nettype none
package cmps_pkg;
   localparam int MaxPointsDefault = 64;
   localparam int CoordWidth = 16;
   localparam int CenterWidth = 17;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 12;
   localparam logic [CsrIndexWidth-1:0] CsrMinDist = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrMaxDist = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrNearRadius = 2'd2;
   localparam logic [11:0] MinDistReset = 12'd100;
   localparam logic [11:0] MaxDistReset = 12'd180;
   localparam logic [7:0] NearRadiusReset = 8'd5;
   localparam logic KindLoad = 1'b0;
   localparam logic KindSearch = 1'b1;

   typedef struct packed {
      logic [CoordWidth-1:0] x;
      logic [CoordWidth-1:0] y;
   } point_type;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_RD_F,
      CMD_RD_L,
      CMD_PAIR,
      CMD_RD_I,
      CMD_NEAR,
      CMD_RD_C,
      CMD_WR_C,
      CMD_CLEAR
   } cmd_type;
endpackage
`default_nettype wire

// ===== rtl/cmps_if.sv =====
`default_nettype none
interface cmps_req_if import cmps_pkg::*; ();
   logic valid;
   logic ready;
   logic kind;
   logic [CoordWidth-1:0] point_x;
   logic [CoordWidth-1:0] point_y;
   modport source(output valid, kind, point_x, point_y, input ready);
   modport sink(input valid, kind, point_x, point_y, output ready);
endinterface

interface cmps_rsp_if import cmps_pkg::*; ();
   logic valid;
   logic ready;
   logic found;
   logic [CoordWidth-1:0] start_x;
   logic [CoordWidth-1:0] start_y;
   logic [CoordWidth-1:0] end_x;
   logic [CoordWidth-1:0] end_y;
   logic [CenterWidth-1:0] center_x;
   logic [CenterWidth-1:0] center_y;
   logic dropped;
   logic last;
   modport source(output valid, found, start_x, start_y, end_x, end_y, center_x, center_y,
      dropped, last, input ready);
   modport sink(input valid, found, start_x, start_y, end_x, end_y, center_x, center_y,
      dropped, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/cmps_ram.sv =====
`default_nettype none
module cmps_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(Depth)-1:0] wr_addr,
   input  wire [Width-1:0]         wr_data,
   input  wire [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]        rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/cmps_datapath.sv =====
`default_nettype none
module cmps_datapath import cmps_pkg::*; #(
   parameter int MaxPoints = MaxPointsDefault,
   localparam int AW = $clog2(MaxPoints),
   localparam int CW = $clog2(MaxPoints + 1)
) (
   input  wire              clock,
   input  wire              reset,
   input  wire cmd_type     cmd,
   input  wire [AW-1:0]     rd_addr,
   input  wire [AW-1:0]     wr_addr,
   input  wire [CW-1:0]     load_count,
   input  wire point_type   load_point,
   input  wire [11:0]       min_dist,
   input  wire [11:0]       max_dist,
   input  wire [7:0]        near_radius,
   output logic             pair_ok,
   output logic             near_q1,
   output logic             near_q3,
   output point_type        f_point,
   output point_type        l_point
);
   point_type rd_data;
   point_type f_ff, l_ff;
   logic wr_en;
   logic [AW-1:0] waddr;
   point_type wdata;
   logic signed [17:0] dx_ff, dy_ff;
   logic pair_ok_ff, q1_ff, q3_ff;

   always_comb begin
      wr_en = 1'b0;
      waddr = wr_addr;
      wdata = rd_data;
      if (cmd == CMD_LOAD) begin
         wr_en = 1'b1;
         waddr = load_count[AW-1:0];
         wdata = load_point;
      end else if (cmd == CMD_WR_C) begin
         wr_en = 1'b1;
      end
   end

   cmps_ram #(.Width(2 * CoordWidth), .Depth(MaxPoints)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(rd_addr), .rd_data(rd_data));

   // pair distance squared
   logic signed [17:0] dx, dy;
   logic signed [35:0] dxsq, dysq;
   logic [35:0] d2;
   logic [31:0] lo2, hi2;
   assign dx = 18'(signed'({2'b0, rd_data.x})) - 18'(signed'({2'b0, f_ff.x}));
   assign dy = 18'(signed'({2'b0, rd_data.y})) - 18'(signed'({2'b0, f_ff.y}));
   assign dxsq = dx * dx;
   assign dysq = dy * dy;
   assign d2 = 36'(dxsq + dysq);
   assign lo2 = {min_dist, 4'b0} * {min_dist, 4'b0};
   assign hi2 = {max_dist, 4'b0} * {max_dist, 4'b0};

   // quarter positions in 1/64 pixel
   logic signed [20:0] q1x, q1y, q3x, q3y, px, py;
   logic signed [21:0] e1x, e1y, e3x, e3y;
   logic signed [43:0] s1x, s1y, s3x, s3y;
   logic [43:0] n1, n3;
   logic [27:0] r2;
   assign q1x = 21'(signed'({3'b0, f_ff.x, 2'b0})) + 21'(dx_ff);
   assign q1y = 21'(signed'({3'b0, f_ff.y, 2'b0})) + 21'(dy_ff);
   assign q3x = 21'(signed'({3'b0, f_ff.x, 2'b0})) + 21'(dx_ff) * 21'sd3;
   assign q3y = 21'(signed'({3'b0, f_ff.y, 2'b0})) + 21'(dy_ff) * 21'sd3;
   assign px = 21'(signed'({3'b0, rd_data.x, 2'b0}));
   assign py = 21'(signed'({3'b0, rd_data.y, 2'b0}));
   assign e1x = 22'(px) - 22'(q1x);
   assign e1y = 22'(py) - 22'(q1y);
   assign e3x = 22'(px) - 22'(q3x);
   assign e3y = 22'(py) - 22'(q3y);
   assign s1x = e1x * e1x;
   assign s1y = e1y * e1y;
   assign s3x = e3x * e3x;
   assign s3y = e3y * e3y;
   assign n1 = 44'(s1x + s1y);
   assign n3 = 44'(s3x + s3y);
   assign r2 = {near_radius, 6'b0} * {near_radius, 6'b0};

   always_ff @(posedge clock) begin
      if (cmd == CMD_RD_F) begin
         f_ff <= rd_data;
      end
      if (cmd == CMD_PAIR) begin
         l_ff <= rd_data;
         dx_ff <= dx;
         dy_ff <= dy;
         pair_ok_ff <= (d2 > 36'(lo2)) && (d2 < 36'(hi2));
      end
      if (cmd == CMD_NEAR) begin
         q1_ff <= n1 <= 44'(r2);
         q3_ff <= n3 <= 44'(r2);
      end
      if (reset) begin
         pair_ok_ff <= 1'b0;
         q1_ff <= 1'b0;
         q3_ff <= 1'b0;
      end
   end

   assign pair_ok = pair_ok_ff;
   assign near_q1 = q1_ff;
   assign near_q3 = q3_ff;
   assign f_point = f_ff;
   assign l_point = l_ff;
endmodule
`default_nettype wire

// ===== rtl/cmps_controller.sv =====
`default_nettype none
module cmps_controller import cmps_pkg::*; #(
   parameter int MaxPoints = MaxPointsDefault,
   localparam int AW = $clog2(MaxPoints),
   localparam int CW = $clog2(MaxPoints + 1)
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire          req_kind,
   input  wire          rsp_ready,
   output logic         rsp_valid,
   output logic         rsp_found,
   output logic         rsp_dropped,
   output logic         rsp_last,
   output cmd_type      cmd,
   output logic [AW-1:0] rd_addr,
   output logic [AW-1:0] wr_addr,
   output logic [CW-1:0] load_count,
   input  wire          pair_ok,
   input  wire          near_q1,
   input  wire          near_q3
);
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_START = 11'b00000000010,
      S_RDF   = 11'b00000000100,
      S_RDL   = 11'b00000001000,
      S_PAIR  = 11'b00000010000,
      S_CHK   = 11'b00000100000,
      S_NRD   = 11'b00001000000,
      S_NEAR  = 11'b00010000000,
      S_NEXT  = 11'b00100000000,
      S_COMP  = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] f_ff, f_in, l_ff, l_in, i_ff, i_in, w_ff, w_in;
   logic [CW-1:0] q1_ff, q1_in, q3_ff, q3_in;
   logic q1v_ff, q1v_in, q3v_ff, q3v_in;
   logic ovf_ff, ovf_in;
   logic found_ff, found_in, last_ff, last_in, valid_ff, valid_in;
   logic comp_rd_ff, comp_rd_in;
   logic drop_i;

   assign load_count = count_ff;
   assign drop_i = (i_ff == f_ff) || (i_ff == l_ff) || (i_ff == q1_ff) || (i_ff == q3_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      f_in = f_ff; l_in = l_ff; i_in = i_ff; w_in = w_ff;
      q1_in = q1_ff; q3_in = q3_ff; q1v_in = q1v_ff; q3v_in = q3v_ff;
      ovf_in = ovf_ff;
      found_in = found_ff; last_in = last_ff; valid_in = valid_ff;
      comp_rd_in = comp_rd_ff;
      cmd = CMD_NONE;
      rd_addr = '0;
      wr_addr = w_ff[AW-1:0];
      req_ready = 1'b0;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !valid_ff;
            if (req_valid && req_ready) begin
               if (req_kind == KindLoad) begin
                  if (count_ff < CW'(MaxPoints)) begin
                     cmd = CMD_LOAD;
                     count_in = count_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            f_in = '0;
            if (count_ff < CW'(4)) begin
               found_in = 1'b0; last_in = 1'b1; valid_in = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_RDF;
            end
         end
         S_RDF: begin
            rd_addr = f_ff[AW-1:0];
            l_in = f_ff + 1'b1;
            state_in = S_RDL;
         end
         S_RDL: begin
            cmd = CMD_RD_F;
            rd_addr = l_ff[AW-1:0];
            state_in = S_PAIR;
         end
         S_PAIR: begin
            cmd = CMD_PAIR;
            state_in = S_CHK;
         end
         S_CHK: begin
            i_in = '0;
            q1v_in = 1'b0; q3v_in = 1'b0;
            q1_in = '1; q3_in = '1;
            state_in = pair_ok ? S_NRD : S_NEXT;
         end
         S_NRD: begin
            rd_addr = i_ff[AW-1:0];
            state_in = S_NEAR;
         end
         S_NEAR: begin
            cmd = CMD_NEAR;
            rd_addr = i_ff[AW-1:0];
            state_in = S_NEXT;
            comp_rd_in = 1'b1;
         end
         S_NEXT: begin
            if (comp_rd_ff) begin
               comp_rd_in = 1'b0;
               if (near_q1 && !q1v_ff) begin
                  q1v_in = 1'b1; q1_in = i_ff;
               end
               if (near_q3 && !q3v_ff) begin
                  q3v_in = 1'b1; q3_in = i_ff;
               end
               if ((q1v_ff || near_q1) && (q3v_ff || near_q3)) begin
                  i_in = '0; w_in = '0;
                  state_in = S_COMP;
               end else if (i_ff + 1'b1 < count_ff) begin
                  i_in = i_ff + 1'b1;
                  state_in = S_NRD;
               end else begin
                  state_in = S_NEXT;
               end
            end else if (l_ff + 1'b1 < count_ff) begin
               l_in = l_ff + 1'b1;
               state_in = S_RDL;
               rd_addr = f_ff[AW-1:0];
            end else if (f_ff + CW'(2) < count_ff) begin
               f_in = f_ff + 1'b1;
               state_in = S_RDF;
            end else begin
               found_in = 1'b0; last_in = 1'b1; valid_in = 1'b1;
               state_in = S_OUT;
            end
            if (!comp_rd_ff && state_in == S_RDL) begin
               state_in = S_RDF;
               f_in = f_ff;
               l_in = l_ff;
            end
         end
         S_COMP: begin
            rd_addr = i_ff[AW-1:0];
            if (comp_rd_ff) begin
               comp_rd_in = 1'b0;
               if (!drop_i) begin
                  cmd = CMD_WR_C;
                  w_in = w_ff + 1'b1;
               end
               if (i_ff + 1'b1 < count_ff) begin
                  i_in = i_ff + 1'b1;
               end else begin
                  count_in = drop_i ? w_ff : w_ff + 1'b1;
                  found_in = 1'b1; last_in = 1'b0; valid_in = 1'b1;
                  state_in = S_OUT;
               end
            end else begin
               comp_rd_in = 1'b1;
            end
         end
         S_OUT: begin
            if (!valid_ff) begin
               if (last_ff) begin
                  count_in = '0;
                  ovf_in = 1'b0;
                  last_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_START;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // l advance inside S_NEXT restarts through S_RDF with l kept
   logic keep_l_ff, keep_l_in;
   always_comb begin
      keep_l_in = (state_ff == S_NEXT) && !comp_rd_ff && (l_ff + 1'b1 < count_ff);
   end

   logic [CW-1:0] l_sel;
   assign l_sel = keep_l_ff ? l_ff : l_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         valid_ff <= 1'b0;
         last_ff <= 1'b0;
         found_ff <= 1'b0;
         comp_rd_ff <= 1'b0;
         q1v_ff <= 1'b0;
         q3v_ff <= 1'b0;
         keep_l_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         valid_ff <= valid_in;
         last_ff <= last_in;
         found_ff <= found_in;
         comp_rd_ff <= comp_rd_in;
         q1v_ff <= q1v_in;
         q3v_ff <= q3v_in;
         keep_l_ff <= keep_l_in;
      end
      f_ff <= f_in;
      l_ff <= (state_ff == S_RDF && keep_l_ff) ? l_ff + 1'b1 : l_sel;
      i_ff <= i_in;
      w_ff <= w_in;
      q1_ff <= q1_in;
      q3_ff <= q3_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_found = found_ff;
   assign rsp_last = last_ff;
   assign rsp_dropped = ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MaxPoints)) else $error("count overflow");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff && rsp_ready) |=> ##1 (count_ff == '0))
      else $error("store not emptied");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("accept while busy");
endmodule
`default_nettype wire

// ===== rtl/collinear_marker_pair_search.sv =====
// collinear marker pair search
// req channel: kind 0 loads one point (x, y in Q12.4) into the store, one per
// cycle while idle; loads into a full store are dropped and flagged. kind 1
// starts a search. rsp channel: one transaction per marker found (ends, and
// midpoint in Q12.5), then a terminating transaction with found=0 and last=1;
// dropped reports lost loads. a search steps through S_RDF, S_RDL, S_PAIR,
// S_CHK and S_NEXT per scanned pair, plus S_NRD, S_NEAR and S_NEXT per stored
// point for each near-point scan and a read and a write step in S_COMP per
// stored point for each compaction pass, all set by the single read port of
// the point memory. with fewer than 4 points stored, S_START goes straight to
// S_OUT and raises rsp_valid. the store is emptied after the terminating
// transaction is taken; the next req transaction is taken once back in S_IDLE.
// csr port writes min/max pair distance and near radius; write only when idle.
// reset empties the store and loads register defaults (100, 180, 5).
// when rsp_ready is low the result is held and no new transaction is accepted.
`default_nettype none
module collinear_marker_pair_search import cmps_pkg::*; #(
   parameter int MaxPoints = MaxPointsDefault
) (
   input wire clock,
   input wire reset,
   cmps_req_if.sink req,
   cmps_rsp_if.source rsp,
   input wire csr_wr_en,
   input wire [CsrIndexWidth-1:0] csr_index,
   input wire [CsrDataWidth-1:0] csr_data
);
   localparam int AW = $clog2(MaxPoints);
   localparam int CW = $clog2(MaxPoints + 1);

   logic [11:0] min_ff, max_ff;
   logic [7:0] rad_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MinDistReset;
         max_ff <= MaxDistReset;
         rad_ff <= NearRadiusReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrMinDist: min_ff <= csr_data;
            CsrMaxDist: max_ff <= csr_data;
            CsrNearRadius: rad_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   cmd_type cmd;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [CW-1:0] load_count;
   logic pair_ok, near_q1, near_q3;
   point_type f_point, l_point, load_point;
   logic found, last;
   assign load_point = '{x: req.point_x, y: req.point_y};

   cmps_controller #(.MaxPoints(MaxPoints)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .req_kind(req.kind), .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
      .rsp_found(found), .rsp_dropped(rsp.dropped), .rsp_last(last), .cmd(cmd),
      .rd_addr(rd_addr), .wr_addr(wr_addr), .load_count(load_count),
      .pair_ok(pair_ok), .near_q1(near_q1), .near_q3(near_q3));

   cmps_datapath #(.MaxPoints(MaxPoints)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr),
      .load_count(load_count), .load_point(load_point), .min_dist(min_ff),
      .max_dist(max_ff), .near_radius(rad_ff), .pair_ok(pair_ok), .near_q1(near_q1),
      .near_q3(near_q3), .f_point(f_point), .l_point(l_point));

   assign rsp.found = found;
   assign rsp.last = last;
   assign rsp.start_x = found ? f_point.x : '0;
   assign rsp.start_y = found ? f_point.y : '0;
   assign rsp.end_x = found ? l_point.x : '0;
   assign rsp.end_y = found ? l_point.y : '0;
   assign rsp.center_x = found ? CenterWidth'(f_point.x) + CenterWidth'(l_point.x) : '0;
   assign rsp.center_y = found ? CenterWidth'(f_point.y) + CenterWidth'(l_point.y) : '0;
endmodule
`default_nettype wire
